// ===== hw/rtl/ppqdk_pkg.sv =====
// ----------------------------------------------------------------------------
// ppqdk_pkg
// Shared types, constants and status codes of the keyed min priority queue.
// ----------------------------------------------------------------------------
package ppqdk_pkg;

    localparam int NUM_KEYS_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 48;
    localparam int MAX_PULL_DEF   = 16;

    localparam int KEY_W    = 10;
    localparam int VALUE_W  = 48;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_PULL   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PULLED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    out_key;
        logic [VALUE_W-1:0]  out_value;
        logic                last;
        logic                now_empty;
    } out_item_t;

endpackage

// ===== hw/rtl/ppqdk_ram.sv =====
// ----------------------------------------------------------------------------
// ppqdk_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppqdk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/partial_priority_queue_decrease_key.sv =====
// ----------------------------------------------------------------------------
// partial_priority_queue_decrease_key
// Keyed minimum priority queue with decrease-key, pull of up to pull_limit
// smallest entries (0 taken as 1, capped at MAX_PULL), and clear. Values live in
// a RAM; live flags in a second RAM that is swept to zero after reset and on clear.
// ----------------------------------------------------------------------------
//  channel   ports                    payload
//  input     s_valid / s_ready        s_data  (op, key, value)
//  result    m_valid / m_ready        m_data  (status, out_key, out_value, last,
//                                              now_empty)
//  config    cfg_valid / cfg_ready    cfg_data (pull_limit)
//
//  Insert: read the key entry, then compare and write back, then output.
//  Pull: per emitted key one scan of all NUM_KEYS entries through the RAM read
//  port; the scan sets the time taken per key.
//  Clear: a sweep of all NUM_KEYS entries of the live RAM; the same sweep follows
//  reset and no input transaction is taken during it.
//  A stalled result holds the block; config writes are always taken.
// ----------------------------------------------------------------------------
module partial_priority_queue_decrease_key
    import ppqdk_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_PULL   = MAX_PULL_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ppqdk_pkg::in_item_t           s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ppqdk_pkg::out_item_t          m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ppqdk_pkg::LIMIT_W-1:0] cfg_data
);
    localparam int AW  = $clog2(NUM_KEYS);
    localparam int CW  = $clog2(NUM_KEYS + 1);
    localparam int PW  = $clog2(MAX_PULL + 1);
    localparam int KWX = (AW > KEY_W) ? AW : KEY_W;

    localparam logic [3:0] S_SWEEP  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_IRD    = 4'd2;
    localparam logic [3:0] S_ICMP   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SLAST  = 4'd5;
    localparam logic [3:0] S_KILL   = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;
    localparam logic [3:0] S_RESCAN = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [PW-1:0]         npull_reg, npull_next;
    logic [PW-1:0]         lim_eff;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  found_reg, found_next;
    logic [AW-1:0]         best_key_reg, best_key_next;
    logic [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic                  scan_v_reg, scan_v_next;
    logic [AW-1:0]         scan_a_reg, scan_a_next;
    logic                  done_reg, done_next;
    out_item_t             out_reg, out_next;
    logic                  mv_reg, mv_next;

    logic                  v_we, l_we, l_wd;
    logic [AW-1:0]         ram_addr;
    logic [VALUE_BITS-1:0] v_wd, v_rd;
    logic                  l_rd;
    logic                  wr_new;
    logic [KWX-1:0]        key_x;
    logic [VALUE_W-1:0]    best_val_out;
    logic [KEY_W-1:0]      best_key_out;
    logic                  pull_empty;

    ppqdk_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_KEYS)) u_val (
        .aclk(aclk), .we(v_we), .addr(ram_addr), .wdata(v_wd), .rdata(v_rd)
    );
    ppqdk_ram #(.WIDTH(1), .DEPTH(NUM_KEYS)) u_live (
        .aclk(aclk), .we(l_we), .addr(ram_addr), .wdata(l_wd), .rdata(l_rd)
    );

    assign key_x        = KWX'(s_data.key);
    assign best_val_out = VALUE_W'(best_val_reg);
    assign best_key_out = KEY_W'(best_key_reg);
    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid      = mv_reg;
    assign m_data       = out_reg;
    // every result of a pull reports what is left once the whole run is done
    assign pull_empty   = 32'(count_reg) <= 32'(lim_eff - npull_reg);

    always_comb begin
        if (limit_reg == '0) begin
            lim_eff = PW'(1);
        end else if (32'(limit_reg) > MAX_PULL) begin
            lim_eff = PW'(MAX_PULL);
        end else begin
            lim_eff = PW'(limit_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        npull_next    = npull_reg;
        val_next      = val_reg;
        found_next    = found_reg;
        best_key_next = best_key_reg;
        best_val_next = best_val_reg;
        scan_v_next   = 1'b0;
        scan_a_next   = scan_a_reg;
        done_next     = done_reg;
        out_next      = out_reg;
        mv_next       = mv_reg && !m_ready;
        v_we          = 1'b0;
        l_we          = 1'b0;
        l_wd          = 1'b0;
        v_wd          = val_reg;
        ram_addr      = addr_reg;
        wr_new        = 1'b0;

        case (state_reg)
            S_SWEEP: begin
                l_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (32'(addr_reg) == NUM_KEYS - 1) begin
                    addr_next = '0;
                    if (done_reg) begin
                        out_next = '{ST_CLEARED, '0, '0, 1'b1, 1'b1};
                        state_next = S_OUT;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    val_next = VALUE_BITS'(s_data.value);
                    case (s_data.op)
                        OP_INSERT: begin
                            if (32'(key_x) < NUM_KEYS) begin
                                addr_next = AW'(s_data.key);
                                ram_addr = AW'(s_data.key);
                                state_next = S_IRD;
                            end else begin
                                out_next = '{ST_IGNORED, '0, '0, 1'b1, count_reg == '0};
                                state_next = S_OUT;
                            end
                        end
                        OP_PULL: begin
                            npull_next = '0;
                            if (count_reg == '0) begin
                                out_next = '{ST_NONE, '0, '0, 1'b1, 1'b1};
                                state_next = S_OUT;
                            end else begin
                                addr_next = '0;
                                ram_addr = '0;
                                found_next = 1'b0;
                                scan_v_next = 1'b1;
                                scan_a_next = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            addr_next = '0;
                            done_next = 1'b1;
                            state_next = S_SWEEP;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_IRD: begin
                state_next = S_ICMP;
            end
            S_ICMP: begin
                // write back when absent or strictly smaller
                if (!l_rd || (val_reg < v_rd)) begin
                    wr_new = !l_rd;
                    v_we = 1'b1;
                    l_we = 1'b1;
                    l_wd = 1'b1;
                    if (wr_new) begin
                        count_next = count_reg + 1'b1;
                    end
                    out_next = '{ST_INSERTED, '0, '0, 1'b1, 1'b0};
                end else begin
                    out_next = '{ST_IGNORED, '0, '0, 1'b1, count_reg == '0};
                end
                state_next = S_OUT;
            end
            S_SCAN: begin
                // issue next address, evaluate data of the previous one
                if (32'(addr_reg) != NUM_KEYS - 1) begin
                    addr_next = addr_reg + 1'b1;
                    ram_addr = addr_reg + 1'b1;
                    scan_v_next = 1'b1;
                    scan_a_next = addr_reg + 1'b1;
                end else begin
                    state_next = S_SLAST;
                end
                if (scan_v_reg && l_rd && (!found_reg || v_rd < best_val_reg)) begin
                    found_next = 1'b1;
                    best_key_next = scan_a_reg;
                    best_val_next = v_rd;
                end
            end
            S_SLAST: begin
                if (l_rd && (!found_reg || v_rd < best_val_reg)) begin
                    best_key_next = scan_a_reg;
                    best_val_next = v_rd;
                end
                state_next = S_KILL;
            end
            S_KILL: begin
                if (!mv_reg || m_ready) begin
                    ram_addr = best_key_reg;
                    l_we = 1'b1;
                    count_next = count_reg - 1'b1;
                    npull_next = npull_reg + 1'b1;
                    mv_next = 1'b1;
                    out_next = '{ST_PULLED, best_key_out, best_val_out, 1'b0,
                                 pull_empty};
                    if (count_reg == CW'(1) || npull_reg + 1'b1 == lim_eff) begin
                        out_next.last = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        // kill now, restart scan next cycle
                        found_next = 1'b0;
                        state_next = S_RESCAN;
                    end
                end
            end
            S_RESCAN: begin
                addr_next = '0;
                ram_addr = '0;
                found_next = 1'b0;
                scan_v_next = 1'b1;
                scan_a_next = '0;
                state_next = S_SCAN;
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    done_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            addr_reg  <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_W'(1);
            npull_reg <= '0;
            found_reg <= 1'b0;
            scan_v_reg <= 1'b0;
            done_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            npull_reg <= npull_next;
            found_reg <= found_next;
            scan_v_reg <= scan_v_next;
            done_reg  <= done_next;
            mv_reg    <= mv_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        best_key_reg <= best_key_next;
        best_val_reg <= best_val_next;
        scan_a_reg   <= scan_a_next;
        out_reg      <= out_next;
    end
endmodule

// ===== tb/sv/tb_partial_priority_queue_decrease_key.sv =====
// ----------------------------------------------------------------------------
// tb_partial_priority_queue_decrease_key
// Self-checking bench for the keyed min priority queue. Inserts, pulls and
// clears go through an untimed model of the store. Each result transaction
// is checked in order against the expected results, with random stalls on
// both channels and several pull_limit settings.
// ----------------------------------------------------------------------------
module tb_partial_priority_queue_decrease_key;
    import ppqdk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS      = NUM_KEYS_DEF;
    localparam int PULL_MAX   = MAX_PULL_DEF;
    localparam int SWEEP_WAIT = NKEYS + 100;
    localparam int CYCLE_CAP  = 30000000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;

    // queue model
    logic               key_live [NKEYS];
    logic [VALUE_W-1:0] key_value [NKEYS];
    int                 live_total;
    logic [LIMIT_W-1:0] limit_reg;

    out_item_t pending_results [$];
    int  error_count;
    int  cycle_count = 0;
    bit  stalls_on;

    partial_priority_queue_decrease_key u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stalls_on) begin
            m_ready <= ($urandom_range(0, 99) >= 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", 64'(m_data.status), 64'(want.status));
                if (m_data.out_key !== want.out_key)
                    report_mismatch("out_key", 64'(m_data.out_key), 64'(want.out_key));
                if (m_data.out_value !== want.out_value)
                    report_mismatch("out_value", 64'(m_data.out_value),
                                    64'(want.out_value));
                if (m_data.last !== want.last)
                    report_mismatch("last", 64'(m_data.last), 64'(want.last));
                if (m_data.now_empty !== want.now_empty)
                    report_mismatch("now_empty", 64'(m_data.now_empty),
                                    64'(want.now_empty));
            end
        end
    end

    function automatic out_item_t make_result(logic [STATUS_W-1:0] st,
                                              logic [KEY_W-1:0] k,
                                              logic [VALUE_W-1:0] v);
        out_item_t r;
        r.status    = st;
        r.out_key   = k;
        r.out_value = v;
        r.last      = 1'b1;
        r.now_empty = (live_total == 0);
        return r;
    endfunction

    // Append one expected result transaction.
    task automatic add_expected(input out_item_t r);
        pending_results = {pending_results, r};
    endtask

    // Apply one accepted transaction to the model and queue its results.
    task automatic apply_queue_op(input in_item_t it);
        int n_pull;
        int best;
        int first_idx;
        int i;
        if (it.op == OP_INSERT) begin
            if (!key_live[it.key]) begin
                key_live[it.key]  = 1'b1;
                key_value[it.key] = it.value;
                live_total++;
                add_expected(make_result(ST_INSERTED, '0, '0));
            end else if (it.value < key_value[it.key]) begin
                key_value[it.key] = it.value;
                add_expected(make_result(ST_INSERTED, '0, '0));
            end else begin
                add_expected(make_result(ST_IGNORED, '0, '0));
            end
        end else if (it.op == OP_PULL) begin
            n_pull = (limit_reg == 0) ? 1 : int'(limit_reg);
            if (n_pull > PULL_MAX) n_pull = PULL_MAX;
            if (live_total == 0) begin
                add_expected(make_result(ST_NONE, '0, '0));
            end else begin
                first_idx = pending_results.size();
                while (n_pull > 0 && live_total > 0) begin
                    best = -1;
                    for (i = 0; i < NKEYS; i++) begin
                        if (key_live[i] && (best < 0 || key_value[i] < key_value[best]))
                            best = i;
                    end
                    key_live[best] = 1'b0;
                    live_total--;
                    add_expected(make_result(ST_PULLED, KEY_W'(best), key_value[best]));
                    n_pull--;
                end
                // fix up flags once the run is known
                for (i = first_idx; i < pending_results.size(); i++) begin
                    pending_results[i].last      = (i == pending_results.size() - 1);
                    pending_results[i].now_empty = (live_total == 0);
                end
            end
        end else if (it.op == OP_CLEAR) begin
            for (i = 0; i < NKEYS; i++) key_live[i] = 1'b0;
            live_total = 0;
            add_expected(make_result(ST_CLEARED, '0, '0));
        end
    endtask

    // Send one transaction; valid stays high afterwards unless an idle follows.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        in_item_t it;
        it.op    = op;
        it.key   = k;
        it.value = v;
        if (stalls_on && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 50);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        apply_queue_op(it);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SWEEP_WAIT) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = lim;
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        if ($urandom_range(0, 1)) return VALUE_W'($urandom_range(0, 15));
        return VALUE_W'({$urandom, $urandom});
    endfunction

    task automatic test_empty_and_insert_rules();
        send_item(OP_PULL, 10'd3, '1);
        send_item(OP_INSERT, 10'd0, '0);
        send_item(OP_INSERT, 10'd1023, '1);
        send_item(OP_INSERT, 10'd5, 48'd100);
        send_item(OP_INSERT, 10'd5, 48'd100);
        send_item(OP_INSERT, 10'd5, 48'd101);
        send_item(OP_INSERT, 10'd5, 48'd50);
        send_item(OP_INSERT, 10'd7, 48'd50);
        send_item(OP_UNUSED, 10'h2aa, 48'h5555_5555_5555);
        drain_results();
    endtask

    task automatic test_pull_order();
        write_limit(5'd31);
        send_item(OP_PULL, '0, '0);
        send_item(OP_PULL, '0, '0);
        send_item(OP_INSERT, 10'd512, 48'haaaa_aaaa_aaaa);
        send_item(OP_INSERT, 10'd9, 48'd7);
        send_item(OP_INSERT, 10'd9, 48'd0);
        drain_results();
        write_limit(5'd0);
        send_item(OP_PULL, '0, '0);
        send_item(OP_CLEAR, '1, '1);
        send_item(OP_PULL, '0, '0);
        send_item(OP_INSERT, 10'd9, 48'd3);
        send_item(OP_PULL, '0, '0);
        send_item(OP_CLEAR, '0, '0);
        drain_results();
    endtask

    task automatic test_random_phase(input logic [LIMIT_W-1:0] lim, input int count);
        int pick;
        logic [KEY_W-1:0] k;
        write_limit(lim);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 47));
            if (pick < 74)      send_item(OP_INSERT, k, rand_value());
            else if (pick < 92) send_item(OP_PULL, k, rand_value());
            else if (pick < 95) send_item(OP_CLEAR, k, rand_value());
            else                send_item(OP_UNUSED, k, rand_value());
        end
        drain_results();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        error_count = 0;
        stalls_on   = 1'b1;
        live_total  = 0;
        limit_reg   = 5'd1;
        for (int i = 0; i < NKEYS; i++) begin
            key_live[i]  = 1'b0;
            key_value[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_insert_rules();
        test_pull_order();
        test_random_phase(5'd3, 80);
        test_random_phase(5'd16, 60);
        stalls_on = 1'b0;
        test_random_phase(5'd9, 60);
        stalls_on = 1'b1;
        test_random_phase(5'd0, 50);
        test_random_phase(5'd31, 60);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ppqdk_pkg.sv
hw/rtl/ppqdk_ram.sv
hw/rtl/partial_priority_queue_decrease_key.sv
tb/sv/tb_partial_priority_queue_decrease_key.sv
